FILE: design/slpd_pkg.sv
// shared types and constants of the sync length prefixed deframer
// no dependencies

package slpd_pkg;

	localparam logic [15:0] HEAD_LEN    = 16'd8;
	localparam logic [15:0] SIZE_OFFSET = 16'd0;
	localparam logic [15:0] SIZE_END    = SIZE_OFFSET + 16'd4;

	localparam logic [7:0]  SYNC_RESET    = 8'h5a;
	localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef enum logic {
		REG_SYNC_VALUE  = 1'b0,
		REG_MAX_MSG_LEN = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_SYNC  = 2'd1,
		KIND_ABORT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_HEAD = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       chunk_end;
	} entry_t;

	typedef struct packed {
		logic   vld;
		entry_t entry;
	} push_t;

	typedef struct packed {
		logic   vld;
		entry_t entry;
	} head_t;

	typedef struct packed {
		phase_t phase;
		logic   pop;
		kind_t  pop_kind;
	} stat_t;

endpackage

FILE: design/slpd_in_if.sv
// request channel carrying received bytes into the deframer
// uses no package

interface slpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       abort;
	logic       chunk_end;

	modport source (output valid, output rx_byte, output abort, output chunk_end,
		input ready);
	modport sink (input valid, input rx_byte, input abort, input chunk_end,
		output ready);
endinterface

FILE: design/slpd_out_if.sv
// request channel carrying message bytes out of the deframer
// uses no package

interface slpd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  msg_byte;
	logic [15:0] byte_index;
	logic        is_last;
	logic [15:0] msg_total;
	logic        oversize;
	logic        chunk_end_out;

	modport source (output valid, output msg_byte, output byte_index, output is_last,
		output msg_total, output oversize, output chunk_end_out, input ready);
	modport sink (input valid, input msg_byte, input byte_index, input is_last,
		input msg_total, input oversize, input chunk_end_out, output ready);
endinterface

FILE: design/slpd_front.sv
// front end: accepts input requests, classifies them and pushes them into the queue
// depends on slpd_pkg and slpd_in_if

module slpd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	slpd_in_if.sink               rx,
	input  logic                  cfg_we,
	input  slpd_pkg::reg_idx_t    cfg_index,
	input  logic [15:0]           cfg_wdata,
	input  logic                  q_full,
	output slpd_pkg::push_t       push
);

	logic [7:0] sync_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= slpd_pkg::SYNC_RESET;
		end else if (cfg_we && cfg_index == slpd_pkg::REG_SYNC_VALUE) begin
			sync_q <= cfg_wdata[7:0];
		end
	end

	assign rx.ready = !q_full;

	always_comb begin
		push.vld             = rx.valid && !q_full;
		push.entry.data      = rx.rx_byte;
		push.entry.chunk_end = rx.chunk_end;
		priority if (rx.abort) begin
			push.entry.kind = slpd_pkg::KIND_ABORT;
		end else if (rx.rx_byte == sync_q) begin
			push.entry.kind = slpd_pkg::KIND_SYNC;
		end else begin
			push.entry.kind = slpd_pkg::KIND_DATA;
		end
	end

endmodule

FILE: design/slpd_queue.sv
// short fifo of classified requests between front and back
// depends on slpd_pkg

module slpd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  slpd_pkg::push_t  push,
	input  logic             pop,
	output logic             full,
	output slpd_pkg::head_t  head
);

	slpd_pkg::entry_t          entries_q [slpd_pkg::QDEPTH];
	logic [slpd_pkg::QAW-1:0]  wr_ptr_q;
	logic [slpd_pkg::QAW-1:0]  rd_ptr_q;
	logic [slpd_pkg::QAW:0]    count_q;
	logic                      do_push;
	logic                      do_pop;

	assign full       = count_q == (slpd_pkg::QAW+1)'(slpd_pkg::QDEPTH);
	assign head.vld   = count_q != '0;
	assign head.entry = entries_q[rd_ptr_q];
	assign do_push    = push.vld && !full;
	assign do_pop     = pop && head.vld;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: design/slpd_back.sv
// back end: framing state machine, size decode and output register
// depends on slpd_pkg and slpd_out_if

module slpd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  slpd_pkg::head_t       head,
	output logic                  pop,
	input  logic                  cfg_we,
	input  slpd_pkg::reg_idx_t    cfg_index,
	input  logic [15:0]           cfg_wdata,
	output slpd_pkg::stat_t       stat,
	slpd_out_if.source            tx
);

	slpd_pkg::phase_t phase_q, phase_d;
	logic [15:0] cnt_q, cnt_d;
	logic [31:0] acc_q, acc_d;
	logic [15:0] tot_q, tot_d;
	logic [15:0] max_q;

	logic        out_vld_q;
	logic [7:0]  byte_q;
	logic [15:0] idx_q;
	logic        last_q;
	logic [15:0] mtot_q;
	logic        ovs_q;
	logic        ce_q;

	logic        res_vld;
	logic [15:0] res_idx;
	logic        res_last;
	logic [15:0] res_mtot;
	logic        res_ovs;

	logic        in_size;
	logic [31:0] acc_sh;
	logic [15:0] cnt_inc;
	logic [16:0] sum;
	logic        sat;

	assign pop = head.vld && (!out_vld_q || tx.ready);

	assign stat.phase    = phase_q;
	assign stat.pop      = pop;
	assign stat.pop_kind = head.entry.kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= slpd_pkg::MAX_LEN_RESET;
		end else if (cfg_we && cfg_index == slpd_pkg::REG_MAX_MSG_LEN) begin
			max_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= slpd_pkg::PH_HUNT;
			cnt_q   <= '0;
			acc_q   <= '0;
			tot_q   <= '0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			acc_q   <= acc_d;
			tot_q   <= tot_d;
		end
	end

	always_comb begin
		in_size = (cnt_q >= slpd_pkg::SIZE_OFFSET) && (cnt_q < slpd_pkg::SIZE_END);
		acc_sh  = in_size ? {acc_q[23:0], head.entry.data} : acc_q;
		cnt_inc = cnt_q + 16'd1;
		sum     = {1'b0, acc_sh[15:0]} + {1'b0, slpd_pkg::HEAD_LEN};
		sat     = (|acc_sh[31:16]) || sum[16];

		phase_d  = phase_q;
		cnt_d    = cnt_q;
		acc_d    = acc_q;
		tot_d    = tot_q;
		res_vld  = 1'b0;
		res_idx  = cnt_q;
		res_last = 1'b0;
		res_mtot = '0;
		res_ovs  = 1'b0;

		if (pop) begin
			if (head.entry.kind == slpd_pkg::KIND_ABORT) begin
				phase_d = slpd_pkg::PH_HUNT;
				cnt_d   = '0;
				acc_d   = '0;
				tot_d   = '0;
			end else begin
				unique case (phase_q)
					slpd_pkg::PH_HEAD: begin
						res_vld = 1'b1;
						acc_d   = acc_sh;
						cnt_d   = cnt_inc;
						if (cnt_inc >= slpd_pkg::HEAD_LEN) begin
							res_mtot = sat ? 16'hffff : sum[15:0];
							priority if (sat || sum[15:0] > max_q) begin
								res_last = 1'b1;
								res_ovs  = 1'b1;
								phase_d  = slpd_pkg::PH_HUNT;
								cnt_d    = '0;
								acc_d    = '0;
								tot_d    = '0;
							end else if (acc_sh == '0) begin
								res_last = 1'b1;
								phase_d  = slpd_pkg::PH_HUNT;
								cnt_d    = '0;
								acc_d    = '0;
								tot_d    = '0;
							end else begin
								phase_d = slpd_pkg::PH_BODY;
								tot_d   = sum[15:0];
							end
						end
					end
					slpd_pkg::PH_BODY: begin
						res_vld  = 1'b1;
						res_mtot = tot_q;
						cnt_d    = cnt_inc;
						if (cnt_inc >= tot_q) begin
							res_last = 1'b1;
							phase_d  = slpd_pkg::PH_HUNT;
							cnt_d    = '0;
							acc_d    = '0;
							tot_d    = '0;
						end
					end
					default: begin
						if (head.entry.kind == slpd_pkg::KIND_SYNC) begin
							phase_d = slpd_pkg::PH_HEAD;
							cnt_d   = '0;
							acc_d   = '0;
							tot_d   = '0;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_vld) begin
			out_vld_q <= 1'b1;
		end else if (tx.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld) begin
			byte_q <= head.entry.data;
			idx_q  <= res_idx;
			last_q <= res_last;
			mtot_q <= res_mtot;
			ovs_q  <= res_ovs;
			ce_q   <= head.entry.chunk_end;
		end
	end

	assign tx.valid         = out_vld_q;
	assign tx.msg_byte      = byte_q;
	assign tx.byte_index    = idx_q;
	assign tx.is_last       = last_q;
	assign tx.msg_total     = mtot_q;
	assign tx.oversize      = ovs_q;
	assign tx.chunk_end_out = ce_q;

endmodule

FILE: design/sync_length_prefixed_deframer.sv
// top level of the sync length prefixed deframer: front, queue and back
// depends on slpd_pkg, slpd_in_if, slpd_out_if, slpd_front, slpd_queue, slpd_back
//
// usage
// rx takes one received byte per request with abort and chunk_end flags;
// tx gives one message byte per request with its index within the message,
// a last flag, the total length (once the header is complete), an oversize
// flag and a copy of chunk_end. bytes are dropped until the sync byte, then
// the header and body are passed on; abort drops the partial message.
// cfg_we/cfg_index/cfg_wdata write sync_value (index 0) and max_msg_len
// (index 1); write them only while the block is idle.
// throughput is one byte per cycle while tx does not stall. an rx request is
// registered in the queue and then in the back end output register before it
// reaches tx. a four-entry queue sits between front and back; when tx stalls,
// the output register holds its request, the queue fills and rx.ready drops
// once it is full. reset empties the queue, clears the output register, puts
// the block in sync hunting and loads sync 0x5a and max 4096.

module sync_length_prefixed_deframer (
	input  logic                  clk,
	input  logic                  arst_n,
	slpd_in_if.sink               rx,
	slpd_out_if.source            tx,
	input  logic                  cfg_we,
	input  slpd_pkg::reg_idx_t    cfg_index,
	input  logic [15:0]           cfg_wdata
);

	slpd_pkg::push_t push;
	slpd_pkg::head_t head;
	slpd_pkg::stat_t stat;
	logic            q_full;
	logic            pop;

	slpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.push      (push)
	);

	slpd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	slpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.stat      (stat),
		.tx        (tx)
	);

	a_ovs_last: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && tx.oversize |-> tx.is_last)
		else $error("oversize without last");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && !tx.oversize && tx.msg_total != 16'd0 |-> tx.byte_index < tx.msg_total)
		else $error("byte index beyond message total");

	a_abort_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pop && stat.pop_kind == slpd_pkg::KIND_ABORT |=> stat.phase == slpd_pkg::PH_HUNT)
		else $error("abort did not return to hunting");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		q_full && !pop |=> !rx.ready)
		else $error("queue full but input still ready");

endmodule
